@@ rtl/core/qpr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package qpr_pkg;

	typedef enum logic {
		CMD_PRODUCT = 1'b0,
		CMD_ROTATE  = 1'b1
	} cmd_t;

	// Word layout between front and back: command in bit 0, then the eight
	// components, each COMP_WIDTH bits, in this order.
	localparam int unsigned CMD_POS  = 0;
	localparam int unsigned NUM_COMP = 8;
	localparam int unsigned IDX_AW   = 0;
	localparam int unsigned IDX_AX   = 1;
	localparam int unsigned IDX_AY   = 2;
	localparam int unsigned IDX_AZ   = 3;
	localparam int unsigned IDX_BW   = 4;
	localparam int unsigned IDX_BX   = 5;
	localparam int unsigned IDX_BY   = 6;
	localparam int unsigned IDX_BZ   = 7;

endpackage

`default_nettype wire

@@ rtl/core/qpr_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qpr_front #(
	parameter int COMP_WIDTH = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic                    command,
	input  wire logic [COMP_WIDTH-1:0]   a_w,
	input  wire logic [COMP_WIDTH-1:0]   a_x,
	input  wire logic [COMP_WIDTH-1:0]   a_y,
	input  wire logic [COMP_WIDTH-1:0]   a_z,
	input  wire logic [COMP_WIDTH-1:0]   b_w,
	input  wire logic [COMP_WIDTH-1:0]   b_x,
	input  wire logic [COMP_WIDTH-1:0]   b_y,
	input  wire logic [COMP_WIDTH-1:0]   b_z,
	output logic                         item_valid,
	output logic [1+qpr_pkg::NUM_COMP*COMP_WIDTH-1:0] item_data,
	input  wire logic                    item_full
);

	localparam int W      = COMP_WIDTH;
	localparam int ITEM_W = 1 + qpr_pkg::NUM_COMP * W;

	logic              valid_q;
	logic [ITEM_W-1:0] item_q;
	logic [ITEM_W-1:0] item_d;
	logic              push;
	logic              load;

	// b_w means nothing to a rotation; clear it so the back end sees a clean word
	always_comb begin
		item_d = '0;
		item_d[qpr_pkg::CMD_POS]              = command;
		item_d[1 + qpr_pkg::IDX_AW*W +: W]    = a_w;
		item_d[1 + qpr_pkg::IDX_AX*W +: W]    = a_x;
		item_d[1 + qpr_pkg::IDX_AY*W +: W]    = a_y;
		item_d[1 + qpr_pkg::IDX_AZ*W +: W]    = a_z;
		item_d[1 + qpr_pkg::IDX_BW*W +: W]    =
			(qpr_pkg::cmd_t'(command) == qpr_pkg::CMD_ROTATE) ? '0 : b_w;
		item_d[1 + qpr_pkg::IDX_BX*W +: W]    = b_x;
		item_d[1 + qpr_pkg::IDX_BY*W +: W]    = b_y;
		item_d[1 + qpr_pkg::IDX_BZ*W +: W]    = b_z;
	end

	assign push     = valid_q && !item_full;
	assign load     = !valid_q || push;
	assign in_stall = !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			item_q <= item_d;
		end
	end

	assign item_valid = valid_q;
	assign item_data  = item_q;

endmodule

`default_nettype wire

@@ rtl/core/qpr_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qpr_queue #(
	parameter int WIDTH = 129
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	output logic                  pop_valid,
	output logic [WIDTH-1:0]      pop_data,
	input  wire logic             pop
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (cnt_q == (PTR_W+1)'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/qpr_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qpr_back #(
	parameter int COMP_WIDTH = 16,
	parameter int FRAC_BITS  = 13
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	input  wire logic [1+qpr_pkg::NUM_COMP*COMP_WIDTH-1:0] item_data,
	output logic                       item_pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [COMP_WIDTH-1:0] r_w,
	output logic signed [COMP_WIDTH-1:0] r_x,
	output logic signed [COMP_WIDTH-1:0] r_y,
	output logic signed [COMP_WIDTH-1:0] r_z
);

	localparam int W   = COMP_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int PW  = 2*W;          // a*b raw product
	localparam int RW  = 2*W + 1 - F;  // a*b rounded
	localparam int SW  = RW + 2;       // four-term sum, doubled difference
	localparam int TW  = W + 1;        // t component
	localparam int QW  = 2*W + 1;      // a*t raw product
	localparam int QRW = 2*W + 2 - F;  // a*t rounded
	localparam int OW  = QRW + 2;      // final sum, also saturation input width

	localparam logic signed [PW:0]   HALF1 = (PW+1)'(1) << (F-1);
	localparam logic signed [QW:0]   HALF2 = (QW+1)'(1) << (F-1);
	localparam logic signed [SW-1:0] TLIM  = {{(SW-W){1'b0}}, {W{1'b1}}};
	localparam logic signed [SW-1:0] NTLIM = -TLIM;
	localparam logic signed [OW-1:0] SMAX  = {{(OW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [OW-1:0] SMIN  = {{(OW-W+1){1'b1}}, {(W-1){1'b0}}};

	function automatic logic signed [RW-1:0] round1(input logic signed [PW-1:0] p);
		logic signed [PW:0] e;
		e = (PW+1)'(p) + HALF1;
		return $signed(e[PW:F]);
	endfunction

	function automatic logic signed [QRW-1:0] round2(input logic signed [QW-1:0] p);
		logic signed [QW:0] e;
		e = (QW+1)'(p) + HALF2;
		return $signed(e[QW:F]);
	endfunction

	function automatic logic signed [TW-1:0] clamp_t(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] c;
		c = (v > TLIM) ? TLIM : ((v < NTLIM) ? NTLIM : v);
		return TW'(c);
	endfunction

	function automatic logic signed [W-1:0] sat(input logic signed [OW-1:0] v);
		logic signed [OW-1:0] c;
		c = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
		return W'(c);
	endfunction

	// stage handshake: a stage takes new contents when empty or when it moves on
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6;

	assign adv_s6 = !vld_s6 || !out_stall;
	assign adv_s5 = !vld_s5 || adv_s6;
	assign adv_s4 = !vld_s4 || adv_s5;
	assign adv_s3 = !vld_s3 || adv_s4;
	assign adv_s2 = !vld_s2 || adv_s3;
	assign adv_s1 = !vld_s1 || adv_s2;

	assign item_pop  = item_valid && adv_s1;
	assign out_valid = vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= item_valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
			if (adv_s5) vld_s5 <= vld_s4;
			if (adv_s6) vld_s6 <= vld_s5;
		end
	end

	// unpack word
	qpr_pkg::cmd_t       cmd_in;
	logic signed [W-1:0] a_in [4];
	logic signed [W-1:0] b_in [4];

	always_comb begin
		cmd_in = qpr_pkg::cmd_t'(item_data[qpr_pkg::CMD_POS]);
		for (int k = 0; k < 4; k++) begin
			a_in[k] = $signed(item_data[1 + (qpr_pkg::IDX_AW + k)*W +: W]);
			b_in[k] = $signed(item_data[1 + (qpr_pkg::IDX_BW + k)*W +: W]);
		end
	end

	// s1: all sixteen a_i*b_j products (rotation uses the cross terms)
	qpr_pkg::cmd_t        cmd_s1;
	logic signed [W-1:0]  a_s1 [4];
	logic signed [W-1:0]  bv_s1 [3];
	logic signed [PW-1:0] prod_s1 [4][4];

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			cmd_s1 <= cmd_in;
			for (int i = 0; i < 4; i++) begin
				a_s1[i] <= a_in[i];
				for (int j = 0; j < 4; j++) begin
					prod_s1[i][j] <= PW'(a_in[i]) * PW'(b_in[j]);
				end
			end
			for (int j = 0; j < 3; j++) begin
				bv_s1[j] <= b_in[j+1];
			end
		end
	end

	// s2: round each product on its own
	qpr_pkg::cmd_t        cmd_s2;
	logic signed [W-1:0]  a_s2 [4];
	logic signed [W-1:0]  bv_s2 [3];
	logic signed [RW-1:0] rnd_s2 [4][4];

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			cmd_s2 <= cmd_s1;
			a_s2   <= a_s1;
			bv_s2  <= bv_s1;
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					rnd_s2[i][j] <= round1(prod_s1[i][j]);
				end
			end
		end
	end

	// s3: Hamilton sums (saturated) and t = 2(q x v) clamped
	logic signed [SW-1:0] sum_c [4];
	logic signed [SW-1:0] d2_c [3];

	always_comb begin
		sum_c[0] = SW'(rnd_s2[0][0]) - SW'(rnd_s2[1][1]) - SW'(rnd_s2[2][2])
			- SW'(rnd_s2[3][3]);
		sum_c[1] = SW'(rnd_s2[0][1]) + SW'(rnd_s2[1][0]) + SW'(rnd_s2[2][3])
			- SW'(rnd_s2[3][2]);
		sum_c[2] = SW'(rnd_s2[0][2]) + SW'(rnd_s2[2][0]) + SW'(rnd_s2[3][1])
			- SW'(rnd_s2[1][3]);
		sum_c[3] = SW'(rnd_s2[0][3]) + SW'(rnd_s2[3][0]) + SW'(rnd_s2[1][2])
			- SW'(rnd_s2[2][1]);
		d2_c[0]  = (SW'(rnd_s2[2][3]) - SW'(rnd_s2[3][2])) <<< 1;
		d2_c[1]  = (SW'(rnd_s2[3][1]) - SW'(rnd_s2[1][3])) <<< 1;
		d2_c[2]  = (SW'(rnd_s2[1][2]) - SW'(rnd_s2[2][1])) <<< 1;
	end

	qpr_pkg::cmd_t        cmd_s3;
	logic signed [W-1:0]  a_s3 [4];
	logic signed [W-1:0]  bv_s3 [3];
	logic signed [W-1:0]  res_s3 [4];
	logic signed [TW-1:0] t_s3 [3];

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			cmd_s3 <= cmd_s2;
			a_s3   <= a_s2;
			bv_s3  <= bv_s2;
			for (int k = 0; k < 4; k++) begin
				res_s3[k] <= sat(OW'(sum_c[k]));
			end
			for (int j = 0; j < 3; j++) begin
				t_s3[j] <= clamp_t(d2_c[j]);
			end
		end
	end

	// s4: q.w*t and the q x t cross terms
	qpr_pkg::cmd_t        cmd_s4;
	logic signed [W-1:0]  bv_s4 [3];
	logic signed [W-1:0]  res_s4 [4];
	logic signed [QW-1:0] mw_s4 [3];
	logic signed [QW-1:0] mc_s4 [6];

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			cmd_s4 <= cmd_s3;
			bv_s4  <= bv_s3;
			res_s4 <= res_s3;
			for (int j = 0; j < 3; j++) begin
				mw_s4[j] <= QW'(a_s3[0]) * QW'(t_s3[j]);
			end
			mc_s4[0] <= QW'(a_s3[2]) * QW'(t_s3[2]);  // ay*tz
			mc_s4[1] <= QW'(a_s3[3]) * QW'(t_s3[1]);  // az*ty
			mc_s4[2] <= QW'(a_s3[3]) * QW'(t_s3[0]);  // az*tx
			mc_s4[3] <= QW'(a_s3[1]) * QW'(t_s3[2]);  // ax*tz
			mc_s4[4] <= QW'(a_s3[1]) * QW'(t_s3[1]);  // ax*ty
			mc_s4[5] <= QW'(a_s3[2]) * QW'(t_s3[0]);  // ay*tx
		end
	end

	// s5: rounding
	qpr_pkg::cmd_t         cmd_s5;
	logic signed [W-1:0]   bv_s5 [3];
	logic signed [W-1:0]   res_s5 [4];
	logic signed [QRW-1:0] rw_s5 [3];
	logic signed [QRW-1:0] rc_s5 [6];

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			cmd_s5 <= cmd_s4;
			bv_s5  <= bv_s4;
			res_s5 <= res_s4;
			for (int j = 0; j < 3; j++) begin
				rw_s5[j] <= round2(mw_s4[j]);
			end
			for (int k = 0; k < 6; k++) begin
				rc_s5[k] <= round2(mc_s4[k]);
			end
		end
	end

	// s6: rotation result v + w*t + q x t saturated, or the product sums; output register
	logic signed [OW-1:0] rot_c [3];

	always_comb begin
		rot_c[0] = OW'(bv_s5[0]) + OW'(rw_s5[0]) + OW'(rc_s5[0]) - OW'(rc_s5[1]);
		rot_c[1] = OW'(bv_s5[1]) + OW'(rw_s5[1]) + OW'(rc_s5[2]) - OW'(rc_s5[3]);
		rot_c[2] = OW'(bv_s5[2]) + OW'(rw_s5[2]) + OW'(rc_s5[4]) - OW'(rc_s5[5]);
	end

	logic signed [W-1:0] r_w_s6, r_x_s6, r_y_s6, r_z_s6;

	always_ff @(posedge clk) begin
		if (adv_s6) begin
			case (cmd_s5)
				qpr_pkg::CMD_ROTATE: begin
					r_w_s6 <= '0;
					r_x_s6 <= sat(rot_c[0]);
					r_y_s6 <= sat(rot_c[1]);
					r_z_s6 <= sat(rot_c[2]);
				end
				default: begin
					r_w_s6 <= res_s5[0];
					r_x_s6 <= res_s5[1];
					r_y_s6 <= res_s5[2];
					r_z_s6 <= res_s5[3];
				end
			endcase
		end
	end

	assign r_w = r_w_s6;
	assign r_x = r_x_s6;
	assign r_y = r_y_s6;
	assign r_z = r_z_s6;

endmodule

`default_nettype wire

@@ rtl/core/quaternion_product_and_rotate.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Path: a result passes the front register, the two-entry queue and stages s1 to s6
// before out_valid shows it, and waits longer while out_stall holds the pipeline.
// Throughput: one word per cycle while out_stall is low; the six-stage multiply/round/sum
// pipeline and the two-entry queue in front of it each move a word every cycle then.
// Reset: arst_n clears all valid flags and queue pointers; no words are in flight.

module quaternion_product_and_rotate #(
	parameter int FRAC_BITS  = 13,
	parameter int COMP_WIDTH = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic                    command,
	input  wire logic [COMP_WIDTH-1:0]   a_w,
	input  wire logic [COMP_WIDTH-1:0]   a_x,
	input  wire logic [COMP_WIDTH-1:0]   a_y,
	input  wire logic [COMP_WIDTH-1:0]   a_z,
	input  wire logic [COMP_WIDTH-1:0]   b_w,
	input  wire logic [COMP_WIDTH-1:0]   b_x,
	input  wire logic [COMP_WIDTH-1:0]   b_y,
	input  wire logic [COMP_WIDTH-1:0]   b_z,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [COMP_WIDTH-1:0] r_w,
	output logic signed [COMP_WIDTH-1:0] r_x,
	output logic signed [COMP_WIDTH-1:0] r_y,
	output logic signed [COMP_WIDTH-1:0] r_z
);

	localparam int ITEM_W = 1 + qpr_pkg::NUM_COMP * COMP_WIDTH;

	logic              fr_valid;
	logic [ITEM_W-1:0] fr_data;
	logic              q_full;
	logic              q_valid;
	logic [ITEM_W-1:0] q_data;
	logic              q_pop;

	qpr_front #(
		.COMP_WIDTH(COMP_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.a_w       (a_w),
		.a_x       (a_x),
		.a_y       (a_y),
		.a_z       (a_z),
		.b_w       (b_w),
		.b_x       (b_x),
		.b_y       (b_y),
		.b_z       (b_z),
		.item_valid(fr_valid),
		.item_data (fr_data),
		.item_full (q_full)
	);

	qpr_queue #(
		.WIDTH(ITEM_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fr_valid),
		.push_data (fr_data),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop_data  (q_data),
		.pop       (q_pop)
	);

	qpr_back #(
		.COMP_WIDTH(COMP_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(q_valid),
		.item_data (q_data),
		.item_pop  (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.r_w       (r_w),
		.r_x       (r_x),
		.r_y       (r_y),
		.r_z       (r_z)
	);

endmodule

`default_nettype wire

@@ rtl/core/qpr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qpr_checker #(
	parameter int COMP_WIDTH = 16
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_stall,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic [COMP_WIDTH-1:0] r_w,
	input wire logic [COMP_WIDTH-1:0] r_x,
	input wire logic [COMP_WIDTH-1:0] r_y,
	input wire logic [COMP_WIDTH-1:0] r_z
);

	// input side only backs up once the whole pipeline is full and held
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("in_stall without a pending result word");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> (!out_valid && !in_stall))
		else $error("control not cleared in reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			($stable(r_w) && $stable(r_x) && $stable(r_y) && $stable(r_z)))
		else $error("result word changed while stalled");

endmodule

bind quaternion_product_and_rotate qpr_checker #(
	.COMP_WIDTH(COMP_WIDTH)
) u_qpr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.r_w      (r_w),
	.r_x      (r_x),
	.r_y      (r_y),
	.r_z      (r_z)
);

`default_nettype wire
